>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. Each macro expects clk and
// arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> rtl/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared constants and register codes of the puncture/depuncture stream core.
// ----------------------------------------------------------------------------
`default_nettype none

package pdp_pkg;

	localparam int DEF_MAX_PATTERN_LENGTH = 64;
	localparam int DEF_VALUE_WIDTH        = 16;
	localparam int DEF_QUEUE_DEPTH        = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_REG_W  = 7;
	localparam int PER_W      = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_PATTERN_MASK   = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_BLOCK_PERIODS  = 3'd3,
		REG_ERASURE_VALUE  = 3'd4
	} reg_idx_t;

	localparam logic MODE_PUNCTURE   = 1'b0;
	localparam logic MODE_DEPUNCTURE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/pdp_fifo.sv
// ----------------------------------------------------------------------------
// pdp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = pdp_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [2**AW];
	logic [AW:0]      wptr_q;
	logic [AW:0]      rptr_q;

	assign empty = (wptr_q == rptr_q);
	assign full  = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
	assign rdata = mem_q[rptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + (AW+1)'(1);
			end
			if (pop && !empty) begin
				rptr_q <= rptr_q + (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q[AW-1:0]] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pdp_walker.sv
// ----------------------------------------------------------------------------
// pdp_walker
// Back end: holds the configuration and the pattern position, walks the
// positions and emits results, stalling on empty input or a full queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pdp_walker #(
	parameter int MAX_PATTERN_LENGTH = pdp_pkg::DEF_MAX_PATTERN_LENGTH,
	parameter int VALUE_WIDTH        = pdp_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pdp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pdp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	input  wire logic [VALUE_WIDTH-1:0]          in_value,
	output logic                                 in_pop,
	input  wire logic                            res_full,
	output logic                                 res_push,
	output logic      [VALUE_WIDTH+2:0]          res_data
);

	localparam int POS_W = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
	localparam int CNT_W = POS_W + 1;
	localparam int PAD_N = 2**POS_W;
	localparam int PER_W = pdp_pkg::PER_W;
	localparam int LEN_W = pdp_pkg::LEN_REG_W;

	logic                          mode_q;
	logic [MAX_PATTERN_LENGTH-1:0] mask_q;
	logic [LEN_W-1:0]              len_q;
	logic [PER_W-1:0]              periods_q;
	logic [VALUE_WIDTH-1:0]        erasure_q;

	logic [POS_W-1:0] pos_q;
	logic [PER_W-1:0] per_q;
	logic             got_q;

	logic [CNT_W-1:0] len_eff;
	logic [PER_W-1:0] per_eff;
	logic [PAD_N-1:0] mask_pad;
	logic [PAD_N-1:0] eff_mask;
	logic             any_kept;
	logic             keep;
	logic             next_keep;
	logic             period_end;
	logic             block_end;
	logic             got_after;
	logic             run_last;
	logic             fire;
	logic             advance;
	logic             restart;
	logic [POS_W-1:0] pos_inc;

	assign cfg_ready = 1'b1;

	// Every register but the erasure value restarts the block.
	always_comb begin
		restart = 1'b0;
		if (cfg_valid) begin
			case (cfg_index)
				pdp_pkg::REG_MODE,
				pdp_pkg::REG_PATTERN_MASK,
				pdp_pkg::REG_PATTERN_LENGTH,
				pdp_pkg::REG_BLOCK_PERIODS: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= pdp_pkg::MODE_PUNCTURE;
			mask_q    <= MAX_PATTERN_LENGTH'(1);
			len_q     <= LEN_W'(1);
			periods_q <= PER_W'(1);
			erasure_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdp_pkg::REG_MODE:           mode_q    <= cfg_data[0];
				pdp_pkg::REG_PATTERN_MASK:   mask_q    <= cfg_data[MAX_PATTERN_LENGTH-1:0];
				pdp_pkg::REG_PATTERN_LENGTH: len_q     <= cfg_data[LEN_W-1:0];
				pdp_pkg::REG_BLOCK_PERIODS:  periods_q <= cfg_data[PER_W-1:0];
				pdp_pkg::REG_ERASURE_VALUE:  erasure_q <= cfg_data[VALUE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (len_q > LEN_W'(MAX_PATTERN_LENGTH)) begin
			len_eff = CNT_W'(MAX_PATTERN_LENGTH);
		end else begin
			len_eff = len_q[CNT_W-1:0];
		end
		per_eff  = (periods_q == '0) ? PER_W'(1) : periods_q;
		mask_pad = PAD_N'(mask_q);
		for (int i = 0; i < PAD_N; i++) begin
			eff_mask[i] = mask_pad[i] && (CNT_W'(i) < len_eff);
		end
	end

	assign any_kept   = |eff_mask;
	assign pos_inc    = pos_q + POS_W'(1);
	assign keep       = eff_mask[pos_q];
	assign next_keep  = eff_mask[pos_inc];
	assign period_end = (({1'b0, pos_q} + CNT_W'(1)) == len_eff);
	assign block_end  = period_end && ((per_q + PER_W'(1)) == per_eff);
	assign got_after  = got_q || keep;
	// A depuncture run closes at the period end or just before the next kept
	// position once its own value has gone out.
	assign run_last   = period_end || (got_after && next_keep);

	assign fire = in_valid && !res_full;

	always_comb begin
		in_pop   = 1'b0;
		res_push = 1'b0;
		advance  = 1'b0;
		res_data = {in_value, 1'b0, 1'b1, block_end};
		if (fire) begin
			if (mode_q == pdp_pkg::MODE_PUNCTURE) begin
				in_pop   = 1'b1;
				advance  = 1'b1;
				res_push = keep;
			end else if (!any_kept) begin
				in_pop = 1'b1;
			end else begin
				in_pop   = run_last;
				advance  = 1'b1;
				res_push = 1'b1;
				res_data = {keep ? in_value : erasure_q, !keep, run_last, block_end};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			per_q <= '0;
			got_q <= 1'b0;
		end else if (restart) begin
			pos_q <= '0;
			per_q <= '0;
			got_q <= 1'b0;
		end else if (advance) begin
			if (period_end) begin
				pos_q <= '0;
				per_q <= block_end ? '0 : per_q + PER_W'(1);
			end else begin
				pos_q <= pos_inc;
			end
			got_q <= (mode_q == pdp_pkg::MODE_DEPUNCTURE) && !run_last && got_after;
		end
	end

	`ASSERT_NEVER(a_pos_in_period, {1'b0, pos_q} >= len_eff, "position beyond pattern length")
	`ASSERT_NEVER(a_per_in_block, per_q >= per_eff, "period count beyond block length")
	`ASSERT_NEVER(a_push_when_full, res_push && res_full, "result pushed into a full queue")
	`ASSERT_PROP(a_pop_on_run_end, res_push && mode_q == pdp_pkg::MODE_DEPUNCTURE |-> in_pop == res_data[1], "input released apart from the end of its run")
	`ASSERT_PROP(a_got_cleared, in_pop |=> !got_q, "kept-value flag survives into the next item")

endmodule

`default_nettype wire

>>> rtl/puncture_depuncture_stream_core.sv
// ----------------------------------------------------------------------------
// puncture_depuncture_stream_core
// Periodic puncturing and depuncturing of a block stream.
// ----------------------------------------------------------------------------
// Usage: input values enter through push/full, results leave through
// empty/pop, and registers are written on the cfg channel (cfg_ready is
// always high). Write configuration only while the core is idle.
// An input queue feeds the position walker, which writes results into an
// output queue, so a stall on either side is absorbed until a queue fills.
// A value pushed while both queues are empty is registered in the input
// queue, then its first result in the output queue that drives the ports.
// Throughput: the walker handles one position per cycle while an item
// waits and the output queue has room. In puncture mode an item takes one
// position, whether kept or dropped. In depuncture mode an item causes
// 1 to pattern_length results, so the output runs at one result per cycle;
// with no kept pattern position an item causes no result and is dropped.
// When pop stays low the output queue fills, the walker holds its position,
// and once the input queue fills full goes high.
// Reset returns the configuration and position registers to their defaults
// and empties both queues; with no clearing pass it is ready out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module puncture_depuncture_stream_core #(
	parameter int MAX_PATTERN_LENGTH = pdp_pkg::DEF_MAX_PATTERN_LENGTH,
	parameter int VALUE_WIDTH        = pdp_pkg::DEF_VALUE_WIDTH,
	parameter int QUEUE_DEPTH        = pdp_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [VALUE_WIDTH-1:0]         value,
	output logic                                empty,
	input  wire logic                           pop,
	output logic      [VALUE_WIDTH-1:0]         value_res,
	output logic                                is_erasure,
	output logic                                last_of_run,
	output logic                                end_of_block,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pdp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RES_W = VALUE_WIDTH + 3;

	logic                   in_empty;
	logic                   in_pop;
	logic [VALUE_WIDTH-1:0] in_value;
	logic                   res_full;
	logic                   res_push;
	logic [RES_W-1:0]       res_data;
	logic [RES_W-1:0]       out_data;

	pdp_fifo #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_in_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (value),
		.pop    (in_pop),
		.empty  (in_empty),
		.rdata  (in_value)
	);

	pdp_walker #(
		.MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
		.VALUE_WIDTH        (VALUE_WIDTH)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (!in_empty),
		.in_value  (in_value),
		.in_pop    (in_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	pdp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_data),
		.pop    (pop),
		.empty  (empty),
		.rdata  (out_data)
	);

	assign value_res    = out_data[RES_W-1:3];
	assign is_erasure   = out_data[2];
	assign last_of_run  = out_data[1];
	assign end_of_block = out_data[0];

endmodule

`default_nettype wire

>>> tb/puncture_depuncture_stream_core_tb.sv
// ----------------------------------------------------------------------------
// puncture_depuncture_stream_core_tb
// Self-checking testbench for the puncture/depuncture stream core. A model of
// the position walker predicts the results of every accepted value, and each
// result transfer is compared field by field with the oldest prediction.
// Directed blocks cover the register extremes and the corner cases. Random
// configurations and values then run with random stalls on both sides.
// ----------------------------------------------------------------------------
module puncture_depuncture_stream_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW            = pdp_pkg::DEF_VALUE_WIDTH;
	localparam int MAX_LEN       = pdp_pkg::DEF_MAX_PATTERN_LENGTH;
	localparam int IDX_W         = pdp_pkg::CFG_IDX_W;
	localparam int DATA_W        = pdp_pkg::CFG_DATA_W;
	localparam int RANDOM_ITEMS  = 120;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 300;
	localparam int CYCLE_LIMIT   = 1500000;

	// Indexes past the last defined register; writes there must change nothing.
	localparam int REG_SPARE_FIRST = pdp_pkg::REG_ERASURE_VALUE + 1;
	localparam int REG_INDEX_COUNT = 2 ** IDX_W;

	typedef struct packed {
		logic [VW-1:0] value_res;
		logic          is_erasure;
		logic          last_of_run;
		logic          end_of_block;
	} pdp_result_t;

	class punct_tracker_t;
		bit            mode;
		bit [63:0]     pat_mask;
		bit [6:0]      pat_len;
		bit [15:0]     periods;
		bit [VW-1:0]   erasure;
		bit [6:0]      pos;
		bit [15:0]     period_cnt;
		pdp_result_t   owed[$];
		int            mismatch_count;

		function new();
			mode           = pdp_pkg::MODE_PUNCTURE;
			pat_mask       = 64'd1;
			pat_len        = 7'd1;
			periods        = 16'd1;
			erasure        = '0;
			pos            = '0;
			period_cnt     = '0;
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				pdp_pkg::REG_MODE:           mode = data[0];
				pdp_pkg::REG_PATTERN_MASK:   pat_mask = data;
				pdp_pkg::REG_PATTERN_LENGTH: pat_len = data[pdp_pkg::LEN_REG_W-1:0];
				pdp_pkg::REG_BLOCK_PERIODS:  periods = data[pdp_pkg::PER_W-1:0];
				pdp_pkg::REG_ERASURE_VALUE: begin
					erasure = data[VW-1:0];
					return;
				end
				default: return;
			endcase
			pos        = '0;
			period_cnt = '0;
		endfunction

		function int unsigned positions_eff();
			if (pat_len == 0)
				return 1;
			if (pat_len > MAX_LEN)
				return MAX_LEN;
			return pat_len;
		endfunction

		function int unsigned periods_eff();
			return (periods == 0) ? 1 : periods;
		endfunction

		// Returns 1 when the step just closed the block.
		function bit step_position(int unsigned len);
			pos++;
			if (pos >= len) begin
				pos = '0;
				period_cnt++;
				if (period_cnt >= periods_eff()) begin
					period_cnt = '0;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void owe(logic [VW-1:0] v, bit era, bit eob);
			pdp_result_t r;
			r.value_res    = v;
			r.is_erasure   = era;
			r.last_of_run  = 1'b0;
			r.end_of_block = eob;
			owed.push_back(r);
		endfunction

		function void close_run();
			pdp_result_t r;
			r = owed.pop_back();
			r.last_of_run = 1'b1;
			owed.push_back(r);
		endfunction

		function void walk_positions(logic [VW-1:0] v);
			int unsigned len;
			bit [63:0]   live;
			int          n;
			bit          kept_seen;
			bit          keep;
			bit          period_end;
			bit          eob;
			len  = positions_eff();
			live = (len >= 64) ? pat_mask : (pat_mask & ((64'd1 << len) - 64'd1));
			if (pos >= len)
				pos = '0;
			if (period_cnt >= periods_eff())
				period_cnt = '0;
			if (mode == pdp_pkg::MODE_PUNCTURE) begin
				keep = live[pos[5:0]];
				eob  = step_position(len);
				if (keep) begin
					owe(v, 1'b0, eob);
					close_run();
				end
				return;
			end
			// An empty pattern neither emits nor moves in depuncture mode.
			if (live == '0)
				return;
			n         = 0;
			kept_seen = 1'b0;
			forever begin
				keep = live[pos[5:0]];
				if (keep && kept_seen)
					break;
				period_end = (pos + 1 >= len);
				eob        = step_position(len);
				if (keep) begin
					owe(v, 1'b0, eob);
					kept_seen = 1'b1;
				end else begin
					owe(erasure, 1'b1, eob);
				end
				n++;
				if (period_end || n >= MAX_LEN)
					break;
			end
			close_run();
		endfunction

		function void flag(string field, logic [VW-1:0] want, logic [VW-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				mismatch_count++;
			end
		endfunction

		function void match_result(pdp_result_t got);
			pdp_result_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result, actual value_res %h is_erasure %b last %b eob %b",
					$time, got.value_res, got.is_erasure, got.last_of_run, got.end_of_block);
				mismatch_count++;
				return;
			end
			want = owed.pop_front();
			flag("value_res", want.value_res, got.value_res);
			flag("is_erasure", want.is_erasure, got.is_erasure);
			flag("last_of_run", want.last_of_run, got.last_of_run);
			flag("end_of_block", want.end_of_block, got.end_of_block);
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              push      = 1'b0;
	logic [VW-1:0]     value     = '0;
	logic              pop       = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;
	logic              full;
	logic              empty;
	logic [VW-1:0]     value_res;
	logic              is_erasure;
	logic              last_of_run;
	logic              end_of_block;
	logic              cfg_ready;

	punct_tracker_t sb = new();

	int tx_gap_max   = 0;
	int rx_gap_max   = 0;
	bit hold_request = 1'b0;
	int cycles       = 0;

	puncture_depuncture_stream_core uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random gaps, plus one long hold-off when asked for.
	initial begin : result_side
		int          hold;
		pdp_result_t got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = $urandom_range(rx_gap_max, 0);
			if (hold_request) begin
				hold         = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold > 0) begin
				pop <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = {value_res, is_erasure, last_of_run, end_of_block};
			sb.match_result(got);
		end
	end

	function automatic int gap_limit();
		case ($urandom_range(2, 0))
			0:       return 0;
			1:       return 3;
			default: return 17;
		endcase
	endfunction

	// Push stays high from one transfer to the next when the next gap is zero.
	task automatic send_item(input logic [VW-1:0] v);
		int gap;
		gap = $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		sb.walk_positions(v);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_item(VW'($urandom));
	endtask

	// Items that cause no result may still be in flight once nothing is owed.
	task automatic drain_results();
		push <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Unused upper data bits carry random junk that the core must ignore.
	task automatic configure(input bit m, input logic [63:0] msk, input logic [6:0] len,
			input logic [15:0] per, input logic [VW-1:0] era);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(pdp_pkg::REG_MODE, {junk[63:1], m});
		write_reg(pdp_pkg::REG_PATTERN_MASK, msk);
		write_reg(pdp_pkg::REG_PATTERN_LENGTH, {junk[63:7], len});
		write_reg(pdp_pkg::REG_BLOCK_PERIODS, {junk[63:16], per});
		write_reg(pdp_pkg::REG_ERASURE_VALUE, {junk[63:16], era});
	endtask

	initial begin : stimulus
		int          sent;
		int          count;
		bit          rmode;
		logic [63:0] rmask;
		logic [6:0]  rlen;
		logic [15:0] rper;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_max = 2;
		rx_gap_max = 3;

		// Reset registers keep every value of a one-position block.
		send_item('0);
		send_item('1);
		send_item(16'hA5A5);
		drain_results();

		// Spare indexes written mid-block must not disturb the position.
		configure(pdp_pkg::MODE_PUNCTURE, '1, 7'd3, 16'd2, '0);
		send_random(2);
		drain_results();
		for (int i = REG_SPARE_FIRST; i < REG_INDEX_COUNT; i++)
			write_reg(IDX_W'(i), {$urandom, $urandom});
		send_random(4);
		drain_results();

		// Zero length and zero periods both act as one.
		configure(pdp_pkg::MODE_PUNCTURE, '1, 7'd0, 16'd0, '0);
		send_random(2);
		drain_results();

		// Length beyond the maximum, kept positions at both ends of the period.
		configure(pdp_pkg::MODE_DEPUNCTURE, 64'h8000_0000_0000_0001, 7'd127, 16'd2, 16'hFFFF);
		send_random(3);
		drain_results();

		// Only the last position kept: a full period of results per value.
		configure(pdp_pkg::MODE_DEPUNCTURE, 64'h8000_0000_0000_0000, 7'd64, 16'd1, 16'h5A5A);
		send_item('1);
		send_item('0);
		drain_results();

		// Kept bits all above the length make the pattern empty.
		configure(pdp_pkg::MODE_DEPUNCTURE, 64'hFFFF_FFFF_FFFF_FF00, 7'd8, 16'd1, 16'h1234);
		send_random(1);
		drain_results();
		configure(pdp_pkg::MODE_PUNCTURE, '0, 7'd4, 16'd1, '0);
		send_random(1);
		drain_results();

		// Final position dropped, so no end-of-block flag shows.
		configure(pdp_pkg::MODE_PUNCTURE, 64'b011, 7'd3, 16'd1, '0);
		send_random(3);
		drain_results();

		// A new erasure value keeps the position; a period write restarts it.
		configure(pdp_pkg::MODE_DEPUNCTURE, 64'b0101, 7'd4, 16'd2, 16'h1111);
		send_random(1);
		drain_results();
		write_reg(pdp_pkg::REG_ERASURE_VALUE, 64'h2222);
		send_random(2);
		drain_results();
		write_reg(pdp_pkg::REG_BLOCK_PERIODS, 64'd2);
		send_random(1);
		drain_results();

		// Hold the result side off long enough for the input to back up.
		configure(pdp_pkg::MODE_PUNCTURE, '1, 7'd5, 16'd3, '0);
		tx_gap_max   = 0;
		rx_gap_max   = 0;
		hold_request = 1'b1;
		send_random(30);
		drain_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			tx_gap_max = gap_limit();
			rx_gap_max = gap_limit();
			if ($urandom_range(4, 0) == 0) begin
				write_reg(pdp_pkg::REG_ERASURE_VALUE, {$urandom, $urandom});
			end else begin
				rmode = 1'($urandom_range(1, 0));
				case ($urandom_range(9, 0))
					6:       rlen = 7'd0;
					7:       rlen = 7'd64;
					8:       rlen = 7'($urandom_range(127, 65));
					9:       rlen = 7'($urandom_range(63, 9));
					default: rlen = 7'($urandom_range(8, 1));
				endcase
				case ($urandom_range(7, 0))
					0:       rmask = '0;
					1:       rmask = '1;
					2:       rmask = 64'd1 << $urandom_range(63, 0);
					3, 4:    rmask = {$urandom, $urandom} & {$urandom, $urandom};
					default: rmask = {$urandom, $urandom};
				endcase
				case ($urandom_range(9, 0))
					0:       rper = 16'd0;
					1:       rper = 16'hFFFF;
					default: rper = 16'($urandom_range(4, 1));
				endcase
				configure(rmode, rmask, rlen, rper, VW'($urandom));
				if ($urandom_range(3, 0) == 0)
					write_reg(IDX_W'($urandom_range(REG_INDEX_COUNT - 1, REG_SPARE_FIRST)),
						{$urandom, $urandom});
			end
			count = $urandom_range(30, 8);
			send_random(count);
			sent += count;
			drain_results();
		end

		if (sb.mismatch_count == 0 && sb.owed.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
